// ----- rtl/core/pccd_pkg.sv -----
`default_nettype none

package pccd_pkg;

    localparam logic [5:0] CHUNK_LENGTH_RESET = 6'd32;
    localparam logic [0:0] REG_CHUNK_LENGTH   = 1'b0;

    localparam logic [1:0] PAIR_ONE   = 2'b01;
    localparam logic [1:0] PAIR_TWO   = 2'b10;
    localparam logic [1:0] PAIR_THREE = 2'b11;

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAIR = 2'd2
    } phase_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_rd;
        logic emit_clr;
        logic push;
        logic flush;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic step_emit;
        logic last_bit;
        logic more_bits;
        logic end_seen;
        logic fill_zero;
        logic emit_done;
        logic push_ok;
        logic flush_ok;
        logic pend_valid;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pccd_if.sv -----
`default_nettype none

interface pccd_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

interface pccd_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_last;

    modport source (output valid, output data_byte, output run_last, input ready);
    modport sink   (input valid, input data_byte, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pccd_ctrl.sv -----
`default_nettype none

module pccd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pccd_pkg::status_t status,
    output pccd_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_EMIT_RD,
        S_EMIT_PUSH,
        S_TAIL,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                cmd.step = 1'b1;
                if (status.step_emit)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (status.last_bit)
                begin
                    state_next = S_TAIL;
                end
            end
            S_EMIT_RD:
            begin
                if (status.emit_done)
                begin
                    cmd.emit_clr = 1'b1;
                    state_next   = status.more_bits ? S_BIT : S_TAIL;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_PUSH;
                end
            end
            S_EMIT_PUSH:
            begin
                if (status.push_ok)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            S_TAIL:
            begin
                if (status.end_seen && !status.fill_zero)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    cmd.clear  = status.end_seen;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pccd_dp.sv -----
`default_nettype none

module pccd_dp #(
    parameter int MAX_CHUNK = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pccd_pkg::cmd_t    cmd,
    output pccd_pkg::status_t      status,
    input  wire logic [5:0]        chunk_length,
    input  wire logic [7:0]        in_code,
    input  wire logic              in_end,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_data,
    output logic                   out_last
);

    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int FW = $clog2(MAX_CHUNK + 1);

    logic [7:0]       mem [MAX_CHUNK];

    logic [7:0]       shift_reg;
    logic [3:0]       rem_reg;
    logic             end_reg;
    pccd_pkg::phase_t phase_reg;
    logic [3:0]       head_reg;
    logic [2:0]       hbl_reg;
    logic [1:0]       pos_reg;
    logic             seen_reg;
    logic [7:0]       part_reg;
    logic [FW-1:0]    fill_reg;
    logic             mode_reg;
    logic [7:0]       max_reg;
    logic [AW-1:0]    maxpos_reg;
    logic [FW-1:0]    idx_reg;
    logic [AW-1:0]    rd_pos_reg;
    logic [7:0]       rd_data_reg;
    logic             pend_valid_reg;
    logic [7:0]       pend_data_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;

    pccd_pkg::phase_t phase_next;
    logic [3:0]       head_next;
    logic [2:0]       hbl_next;
    logic [1:0]       pos_next;
    logic             seen_next;
    logic [7:0]       part_next;
    logic [FW-1:0]    fill_next;
    logic             mode_next;
    logic [7:0]       max_next;
    logic [AW-1:0]    maxpos_next;

    logic             bit_in;
    logic             do_seek;
    logic [3:0]       seek_mask;
    logic [3:0]       cand;
    logic             found;
    logic [1:0]       found_pos;
    logic             finish;
    logic             store_en;
    logic             full;
    logic [6:0]       len_ext;
    logic [6:0]       eff_len;
    logic [7:0]       result;
    logic             out_free;

    assign bit_in  = shift_reg[7];
    assign len_ext = {1'b0, chunk_length};

    always_comb
    begin
        if (len_ext == 7'd0)
        begin
            eff_len = 7'd1;
        end
        else if (len_ext > 7'(MAX_CHUNK))
        begin
            eff_len = 7'(MAX_CHUNK);
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        head_next   = head_reg;
        hbl_next    = hbl_reg;
        pos_next    = pos_reg;
        seen_next   = seen_reg;
        part_next   = part_reg;
        fill_next   = fill_reg;
        mode_next   = mode_reg;
        max_next    = max_reg;
        maxpos_next = maxpos_reg;
        do_seek     = 1'b0;
        seek_mask   = 4'b1111;
        cand        = 4'b0000;
        found       = 1'b0;
        found_pos   = 2'd0;
        finish      = 1'b0;
        store_en    = 1'b0;
        full        = 1'b0;

        case (phase_reg)
            pccd_pkg::PH_HEAD:
            begin
                head_next = {head_reg[2:0], bit_in};
                hbl_next  = (hbl_reg != 3'd0) ? hbl_reg - 3'd1 : 3'd0;
                if (hbl_next == 3'd0)
                begin
                    part_next = 8'd0;
                    do_seek   = 1'b1;
                    seek_mask = 4'b1111;
                end
            end
            pccd_pkg::PH_PAIR:
            begin
                seek_mask = (4'b0001 << pos_reg) - 4'b0001;
                if (!seen_reg)
                begin
                    if (!bit_in)
                    begin
                        part_next = part_reg | ({6'd0, pccd_pkg::PAIR_ONE} << {pos_reg, 1'b0});
                        do_seek   = 1'b1;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                    end
                end
                else
                begin
                    part_next = part_reg | ({6'd0, bit_in ? pccd_pkg::PAIR_THREE
                                                          : pccd_pkg::PAIR_TWO}
                                            << {pos_reg, 1'b0});
                    seen_next = 1'b0;
                    do_seek   = 1'b1;
                end
            end
            default:
            begin
                mode_next  = bit_in;
                head_next  = 4'd0;
                hbl_next   = 3'd4;
                phase_next = pccd_pkg::PH_HEAD;
            end
        endcase

        if (do_seek)
        begin
            cand = head_next & seek_mask;
            for (int p = 0; p < 4; p++)
            begin
                if (cand[p])
                begin
                    found     = 1'b1;
                    found_pos = 2'(p);
                end
            end
            if (found)
            begin
                pos_next   = found_pos;
                seen_next  = 1'b0;
                phase_next = pccd_pkg::PH_PAIR;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        if (finish)
        begin
            store_en = (7'(fill_reg) < 7'(MAX_CHUNK));
            if (store_en)
            begin
                if (fill_reg == '0 || part_next > max_reg)
                begin
                    max_next    = part_next;
                    maxpos_next = fill_reg[AW-1:0];
                end
                fill_next = fill_reg + FW'(1);
            end
            head_next  = 4'd0;
            hbl_next   = 3'd4;
            seen_next  = 1'b0;
            full       = (7'(fill_next) >= eff_len);
            phase_next = full ? pccd_pkg::PH_MODE : pccd_pkg::PH_HEAD;
        end
    end

    assign result = (mode_reg && rd_pos_reg != maxpos_reg) ? max_reg - rd_data_reg
                                                           : rd_data_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.step_emit  = full;
        status.last_bit   = (rem_reg == 4'd1);
        status.more_bits  = (rem_reg != 4'd0);
        status.end_seen   = end_reg;
        status.fill_zero  = (fill_reg == '0);
        status.emit_done  = (idx_reg == fill_reg);
        status.push_ok    = !pend_valid_reg || out_free;
        status.flush_ok   = out_free;
        status.pend_valid = pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= 4'd0;
            end_reg        <= 1'b0;
            phase_reg      <= pccd_pkg::PH_MODE;
            head_reg       <= 4'd0;
            hbl_reg        <= 3'd0;
            pos_reg        <= 2'd3;
            seen_reg       <= 1'b0;
            part_reg       <= 8'd0;
            fill_reg       <= '0;
            mode_reg       <= 1'b0;
            max_reg        <= 8'd0;
            maxpos_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg <= 4'd8;
                end_reg <= in_end;
            end
            if (cmd.step)
            begin
                rem_reg    <= rem_reg - 4'd1;
                phase_reg  <= phase_next;
                head_reg   <= head_next;
                hbl_reg    <= hbl_next;
                pos_reg    <= pos_next;
                seen_reg   <= seen_next;
                part_reg   <= part_next;
                fill_reg   <= fill_next;
                mode_reg   <= mode_next;
                max_reg    <= max_next;
                maxpos_reg <= maxpos_next;
            end
            if (cmd.emit_rd)
            begin
                idx_reg <= idx_reg + FW'(1);
            end
            if (cmd.emit_clr)
            begin
                idx_reg    <= '0;
                fill_reg   <= '0;
                max_reg    <= 8'd0;
                maxpos_reg <= '0;
            end
            if (cmd.clear)
            begin
                end_reg    <= 1'b0;
                phase_reg  <= pccd_pkg::PH_MODE;
                head_reg   <= 4'd0;
                hbl_reg    <= 3'd0;
                pos_reg    <= 2'd3;
                seen_reg   <= 1'b0;
                part_reg   <= 8'd0;
                fill_reg   <= '0;
                mode_reg   <= 1'b0;
                max_reg    <= 8'd0;
                maxpos_reg <= '0;
            end
            if (cmd.push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.push && pend_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shift_reg <= in_code;
        end
        else if (cmd.step)
        begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
        if (cmd.step && store_en)
        begin
            mem[fill_reg[AW-1:0]] <= part_next;
        end
        if (cmd.emit_rd)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
            rd_pos_reg  <= idx_reg[AW-1:0];
        end
        if (cmd.push)
        begin
            pend_data_reg <= result;
        end
        if (cmd.push && pend_valid_reg)
        begin
            out_data_reg <= pend_data_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_data_reg <= pend_data_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pair_code_chunk_decoder_top.sv -----
// Operation: a code byte is accepted while idle, then decoded one code bit per cycle
// through the shared bit decoder while no chunk is being emitted; each emitted byte passes
// through a read state and a push state. A new code byte is accepted only after the previous
// one is decoded and the bytes it completed are emitted; output stalls delay this further.
// Reset: rst_n is asynchronous and active low; it clears the parser, the chunk fill
// and the output stage, and sets chunk_length to 32. The chunk memory is not cleared.
`default_nettype none

module pair_code_chunk_decoder_top #(
    parameter int MAX_CHUNK = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    pccd_code_if.sink        code_in,
    pccd_data_if.source      data_out
);

    logic [5:0]        chunk_length_reg;
    logic [5:0]        chunk_length_next;
    logic              cfg_write;
    pccd_pkg::cmd_t    cmd;
    pccd_pkg::status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == pccd_pkg::REG_CHUNK_LENGTH);

    always_comb
    begin
        chunk_length_next = cfg_write ? pwdata[5:0] : chunk_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_length_reg <= pccd_pkg::CHUNK_LENGTH_RESET;
        end
        else
        begin
            chunk_length_reg <= chunk_length_next;
        end
    end

    assign prdata = (paddr[2] == pccd_pkg::REG_CHUNK_LENGTH) ? {26'd0, chunk_length_reg}
                                                             : 32'd0;

    pccd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (code_in.valid),
        .in_ready (code_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pccd_dp #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .chunk_length (chunk_length_reg),
        .in_code      (code_in.code_byte),
        .in_end       (code_in.stream_end),
        .out_valid    (data_out.valid),
        .out_ready    (data_out.ready),
        .out_data     (data_out.data_byte),
        .out_last     (data_out.run_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pccd_chk.sv -----
`default_nettype none

module pccd_chk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  out_data,
    input  wire logic        out_last,
    input  wire logic        psel,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] prdata,
    input  wire logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data) && $stable(out_last))
        else $error("Output payload changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input accepted again right after a transaction.");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("Configuration port inserted a wait state.");

    a_unmapped_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && paddr[2] |-> prdata == 32'd0)
        else $error("Unmapped register read returned nonzero data.");

endmodule

bind pair_code_chunk_decoder_top pccd_chk u_pccd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (code_in.valid),
    .in_ready  (code_in.ready),
    .out_valid (data_out.valid),
    .out_ready (data_out.ready),
    .out_data  (data_out.data_byte),
    .out_last  (data_out.run_last),
    .psel      (psel),
    .paddr     (paddr),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire

// ----- test/pair_decode_monitor.sv -----
module pair_decode_monitor
    import pccd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    pccd_code_if        code_mon,
    pccd_data_if        data_mon,
    output int          mismatch_count,
    output int          bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CHUNK = 32;
    localparam logic [2:0] LENGTH_ADDR = {REG_CHUNK_LENGTH, 2'b00};

    typedef struct {
        logic [7:0] data_byte;
        logic       run_last;
    } restored_t;

    restored_t  expected_bytes[$];

    logic [5:0] length_reg;
    phase_t     parse_state;
    logic [3:0] head_bits;
    logic [2:0] head_remaining;
    logic [1:0] pair_slot;
    logic       lead_one;
    logic [7:0] byte_acc;
    logic [7:0] chunk_mem [MAX_CHUNK];
    int         chunk_count;
    logic       chunk_mode;
    logic [7:0] peak_value;
    int         peak_index;

    function automatic int effective_length();
        if (length_reg == 6'd0)
        begin
            return 1;
        end
        if (length_reg > MAX_CHUNK)
        begin
            return MAX_CHUNK;
        end
        return int'(length_reg);
    endfunction

    task clear_stream();
        parse_state    = PH_MODE;
        head_bits      = 4'd0;
        head_remaining = 3'd0;
        pair_slot      = 2'd3;
        lead_one       = 1'b0;
        byte_acc       = 8'd0;
        chunk_count    = 0;
        chunk_mode     = 1'b0;
        peak_value     = 8'd0;
        peak_index     = 0;
    endtask

    task emit_chunk();
        int        j;
        restored_t r;
        for (j = 0; j < chunk_count; j++)
        begin
            r.data_byte = chunk_mem[j];
            if (chunk_mode && j != peak_index)
            begin
                r.data_byte = peak_value - chunk_mem[j];
            end
            r.run_last = 1'b0;
            expected_bytes.push_back(r);
        end
        chunk_count = 0;
        peak_value  = 8'd0;
        peak_index  = 0;
    endtask

    task finish_byte();
        if (chunk_count < MAX_CHUNK)
        begin
            if (chunk_count == 0 || byte_acc > peak_value)
            begin
                peak_value = byte_acc;
                peak_index = chunk_count;
            end
            chunk_mem[chunk_count] = byte_acc;
            chunk_count++;
        end
        head_bits      = 4'd0;
        head_remaining = 3'd4;
        lead_one       = 1'b0;
        if (chunk_count >= effective_length())
        begin
            emit_chunk();
            parse_state = PH_MODE;
        end
        else
        begin
            parse_state = PH_HEAD;
        end
    endtask

    task seek_pair(input int from);
        int   p;
        logic found;
        found = 1'b0;
        for (p = from; p >= 0; p--)
        begin
            if (!found && head_bits[p])
            begin
                pair_slot   = 2'(p);
                lead_one    = 1'b0;
                parse_state = PH_PAIR;
                found       = 1'b1;
            end
        end
        if (!found)
        begin
            finish_byte();
        end
    endtask

    task take_bit(input logic b);
        case (parse_state)
            PH_HEAD:
            begin
                head_bits = {head_bits[2:0], b};
                if (head_remaining > 0)
                begin
                    head_remaining = head_remaining - 3'd1;
                end
                if (head_remaining == 0)
                begin
                    byte_acc = 8'd0;
                    seek_pair(3);
                end
            end
            PH_PAIR:
            begin
                if (!lead_one)
                begin
                    if (!b)
                    begin
                        byte_acc = byte_acc | (8'(PAIR_ONE) << (2 * pair_slot));
                        seek_pair(int'(pair_slot) - 1);
                    end
                    else
                    begin
                        lead_one = 1'b1;
                    end
                end
                else
                begin
                    byte_acc = byte_acc | (8'(b ? PAIR_THREE : PAIR_TWO) << (2 * pair_slot));
                    lead_one = 1'b0;
                    seek_pair(int'(pair_slot) - 1);
                end
            end
            default:
            begin
                chunk_mode     = b;
                head_bits      = 4'd0;
                head_remaining = 3'd4;
                parse_state    = PH_HEAD;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        restored_t want;
        restored_t tail;
        int        count_before;
        int        b;
        if (!rst_n)
        begin
            expected_bytes.delete();
            mismatch_count = 0;
            length_reg     = CHUNK_LENGTH_RESET;
            clear_stream();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LENGTH_ADDR)
            begin
                length_reg = pwdata[5:0];
            end
            if (data_mon.valid && data_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: data_byte %02h run_last %0b arrived with none expected",
                             $time, data_mon.data_byte, data_mon.run_last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_mon.data_byte !== want.data_byte)
                    begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data_byte, data_mon.data_byte);
                        mismatch_count++;
                    end
                    if (data_mon.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.run_last, data_mon.run_last);
                        mismatch_count++;
                    end
                end
            end
            if (code_mon.valid && code_mon.ready)
            begin
                count_before = expected_bytes.size();
                for (b = 7; b >= 0; b--)
                begin
                    take_bit(code_mon.code_byte[b]);
                end
                if (code_mon.stream_end)
                begin
                    if (chunk_count > 0)
                    begin
                        emit_chunk();
                    end
                    clear_stream();
                end
                if (expected_bytes.size() > count_before)
                begin
                    tail = expected_bytes.pop_back();
                    tail.run_last = 1'b1;
                    expected_bytes.push_back(tail);
                end
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

// ----- test/pair_code_chunk_decoder_top_tb.sv -----
module pair_code_chunk_decoder_top_tb;
    import pccd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [2:0] LENGTH_ADDR = {REG_CHUNK_LENGTH, 2'b00};

    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          bytes_pending;
    int          cycle_count = 0;
    int          items_sent = 0;
    logic [5:0]  cur_len = CHUNK_LENGTH_RESET;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    pccd_code_if code_ch ();
    pccd_data_if data_ch ();

    pair_code_chunk_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .code_in  (code_ch),
        .data_out (data_ch)
    );

    pair_decode_monitor decode_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .code_mon       (code_ch),
        .data_mon       (data_ch),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task send_code(input logic [7:0] code, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            code_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        code_ch.valid      <= 1'b1;
        code_ch.code_byte  <= code;
        code_ch.stream_end <= last;
        do @(posedge clk); while (!code_ch.ready);
        items_sent++;
    endtask

    task settle();
        code_ch.valid <= 1'b0;
        do @(posedge clk); while (bytes_pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task set_length(input logic [5:0] len);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LENGTH_ADDR;
        pwdata  <= 32'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_len = len;
    endtask

    function automatic logic [7:0] pick_value(input logic [7:0] prev);
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return prev;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mode_sel 0 or 1 forces the mode bit of every chunk; above 1 draws it at random.
    task automatic send_stream(input byte_q_t vals, input int mode_sel, input bit ended,
                               input int drop_bits);
        bit         bits[$];
        int         eff;
        int         k;
        int         i;
        int         n_bytes;
        logic [1:0] pair;
        logic [7:0] v;
        logic [7:0] code;
        eff = (cur_len == 6'd0) ? 1 : (cur_len > 6'd32) ? 32 : int'(cur_len);
        for (k = 0; k < vals.size(); k++)
        begin
            if (k % eff == 0)
            begin
                bits.push_back(mode_sel > 1 ? bit'($urandom_range(0, 1)) : bit'(mode_sel));
            end
            v = vals[k];
            for (i = 3; i >= 0; i--)
            begin
                bits.push_back(v[2*i +: 2] != 2'b00);
            end
            for (i = 3; i >= 0; i--)
            begin
                pair = v[2*i +: 2];
                if (pair == PAIR_ONE)
                begin
                    bits.push_back(1'b0);
                end
                else if (pair == PAIR_TWO)
                begin
                    bits.push_back(1'b1);
                    bits.push_back(1'b0);
                end
                else if (pair == PAIR_THREE)
                begin
                    bits.push_back(1'b1);
                    bits.push_back(1'b1);
                end
            end
        end
        repeat (drop_bits)
        begin
            if (bits.size() > 1)
            begin
                void'(bits.pop_back());
            end
        end
        while (bits.size() % 8 != 0)
        begin
            bits.push_back(bit'($urandom_range(0, 1)));
        end
        n_bytes = bits.size() / 8;
        for (k = 0; k < n_bytes; k++)
        begin
            for (i = 0; i < 8; i++)
            begin
                code[7-i] = bits[8*k+i];
            end
            send_code(code, ended && k == n_bytes - 1);
        end
    endtask

    initial
    begin
        int stall;
        data_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (hold_off)
            begin
                stall    = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (stall > 0)
            begin
                data_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            data_ch.ready <= 1'b1;
            do @(posedge clk); while (!data_ch.valid);
        end
    end

    initial
    begin
        byte_q_t    vals;
        logic [7:0] v;
        logic [5:0] len;
        int         directed_items;
        int         phase_no;
        int         eff;
        int         n;
        int         kind;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= 3'd0;
        pwdata             <= 32'd0;
        code_ch.valid      <= 1'b0;
        code_ch.code_byte  <= 8'd0;
        code_ch.stream_end <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_code(8'h00, 1'b1);
        send_code(8'hFF, 1'b1);
        vals = '{8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h07, 8'hC3};
        send_stream(vals, 1, 1'b1, 0);
        set_length(6'd0);
        vals = '{8'h12, 8'h00, 8'h3F};
        send_stream(vals, 0, 1'b1, 0);
        set_length(6'd63);
        vals = '{8'h9C, 8'h9C, 8'h40};
        send_stream(vals, 1, 1'b1, 0);
        set_length(6'd8);
        vals = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        send_stream(vals, 1, 1'b0, 0);
        set_length(6'd2);
        vals = '{8'h66, 8'hE4};
        send_stream(vals, 1, 1'b1, 0);
        directed_items = items_sent;

        phase_no = 0;
        v = 8'h00;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = 6'($urandom_range(1, 6));
                5:             len = 6'($urandom_range(7, 16));
                6:             len = 6'd32;
                7:             len = 6'd0;
                8:             len = 6'($urandom_range(33, 63));
                default:       len = 6'($urandom_range(17, 31));
            endcase
            if (phase_no == 2)
            begin
                len = 6'd4;
            end
            set_length(len);
            calm = ($urandom_range(0, 3) == 0);
            eff = (cur_len == 6'd0) ? 1 : (cur_len > 6'd32) ? 32 : int'(cur_len);
            if (phase_no == 2)
            begin
                vals.delete();
                repeat (60)
                begin
                    v = pick_value(v);
                    vals.push_back(v);
                end
                hold_off = 1'b1;
                send_stream(vals, 2, 1'b1, 0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    kind = $urandom_range(0, 9);
                    if (kind <= 7)
                    begin
                        n = $urandom_range(1, (eff * 2 > 40) ? 40 : eff * 2);
                        vals.delete();
                        repeat (n)
                        begin
                            v = pick_value(v);
                            vals.push_back(v);
                        end
                        send_stream(vals, 2, 1'b1, (kind == 7) ? $urandom_range(1, 6) : 0);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 6))
                        begin
                            send_code(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                        end
                        send_code(8'($urandom_range(0, 255)), 1'b1);
                    end
                end
            end
            phase_no++;
        end
        calm = 1'b0;

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
